// ----- rtl/core/fir103_pkg.sv -----
// Shared constants for the 103-tap FIR filter: tap count, widths and the
// fixed symmetric coefficient table.
// No dependencies.
`default_nettype none

package fir103_pkg;

  localparam int unsigned TAP_COUNT    = 103;
  localparam int unsigned COEFF_W      = 16;
  // sum of |coeff| is below 2**18, so the accumulator needs this many bits
  // on top of the sample width
  localparam int unsigned COEFF_SUM_W  = 18;
  localparam int unsigned OUTPUT_SHIFT = 16;
  localparam int unsigned FILTERED_W   = 18;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 24;

  // coefficient i weights the sample i steps back
  localparam logic signed [COEFF_W-1:0] COEFFS [TAP_COUNT] = '{
    -16'sd501,  -16'sd458,  -16'sd618,  -16'sd772,  -16'sd899,
    -16'sd982,  -16'sd1004, -16'sd955,  -16'sd830,  -16'sd636,
    -16'sd388,  -16'sd107,   16'sd178,   16'sd434,   16'sd632,
     16'sd747,   16'sd764,   16'sd681,   16'sd508,   16'sd268,
    -16'sd4,    -16'sd269,  -16'sd486,  -16'sd618,  -16'sd640,
    -16'sd542,  -16'sd330,  -16'sd31,    16'sd316,   16'sd659,
     16'sd942,   16'sd1115,  16'sd1138,  16'sd991,   16'sd678,
     16'sd229,  -16'sd304,  -16'sd845,  -16'sd1311, -16'sd1615,
    -16'sd1680, -16'sd1450, -16'sd896,  -16'sd26,    16'sd1119,
     16'sd2461,  16'sd3896,  16'sd5305,  16'sd6564,  16'sd7558,
     16'sd8194,  16'sd8414,  16'sd8194,  16'sd7558,  16'sd6564,
     16'sd5305,  16'sd3896,  16'sd2461,  16'sd1119, -16'sd26,
    -16'sd896,  -16'sd1450, -16'sd1680, -16'sd1615, -16'sd1311,
    -16'sd845,  -16'sd304,   16'sd229,   16'sd678,   16'sd991,
     16'sd1138,  16'sd1115,  16'sd942,   16'sd659,   16'sd316,
    -16'sd31,   -16'sd330,  -16'sd542,  -16'sd640,  -16'sd618,
    -16'sd486,  -16'sd269,  -16'sd4,     16'sd268,   16'sd508,
     16'sd681,   16'sd764,   16'sd747,   16'sd632,   16'sd434,
     16'sd178,  -16'sd107,  -16'sd388,  -16'sd636,  -16'sd830,
    -16'sd955,  -16'sd1004, -16'sd982,  -16'sd899,  -16'sd772,
    -16'sd618,  -16'sd458,  -16'sd501
  };

endpackage

`default_nettype wire

// ----- rtl/core/fir103_cell.sv -----
// One tap of the transposed-form FIR chain: multiply the broadcast sample by
// a fixed coefficient and add the partial sum handed over by the next tap.
// Depends on fir103_pkg for the coefficient width.
`default_nettype none

module fir103_cell #(
  parameter int unsigned SAMPLE_W = 16,
  parameter int unsigned ACC_W    = 34,
  parameter logic signed [fir103_pkg::COEFF_W-1:0] COEFF = '0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic signed [ACC_W-1:0]    sum_i,
  output logic signed [ACC_W-1:0]         sum_o
);

  localparam int unsigned PROD_W = SAMPLE_W + fir103_pkg::COEFF_W;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum_d;
  logic signed [ACC_W-1:0]  sum_q;

  // tap product plus upstream partial sum
  assign prod  = sample_i * COEFF;
  assign sum_d = ACC_W'(prod) + sum_i;

  // partial sum register; reset matches an all-zero history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- rtl/core/fir_filter_103_tap.sv -----
// Top level of the 103-tap FIR filter: a row of fir103_cell taps in
// transposed form plus the stream handshake.
// Depends on fir103_pkg and fir103_cell.
`default_nettype none

// Channel   Dir  tdata fields (low bit up)        Width
// s_axis    in   sample[15:0] signed              16
// m_axis    out  filtered[17:0] signed, 6 zeros   24
//
// One sample per clock unless the output stalls: every tap cell updates its
// partial sum in the cycle a sample transfers, so throughput is set by the
// single cell stage. The result of a sample is shown in the cycle after its
// transfer, from the first cell's register. Reset clears every partial sum
// (an all-zero history). A stalled output holds the chain; input is taken
// when the output is empty or being taken in the same cycle.

module fir_filter_103_tap #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [fir103_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // sample
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [fir103_pkg::OUT_TDATA_W-1:0]       m_axis_tdata   // filtered, zero fill
);

  localparam int unsigned ACC_W = SAMPLE_WIDTH + fir103_pkg::COEFF_SUM_W;

  logic                            in_xfer;
  logic                            out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  sample;
  logic signed [ACC_W-1:0]         chain [fir103_pkg::TAP_COUNT+1];
  logic signed [ACC_W-1:0]         shifted;

  // handshake: output register doubles as the first cell's sum
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // only the low sample bits count, sign-extended inside each cell
  assign sample = s_axis_tdata[SAMPLE_WIDTH-1:0];

  // tap chain: the last tap starts from zero, tap 0 holds the full sum
  assign chain[fir103_pkg::TAP_COUNT] = '0;

  for (genvar k = 0; k < fir103_pkg::TAP_COUNT; k++) begin : g_tap
    fir103_cell #(
      .SAMPLE_W (SAMPLE_WIDTH),
      .ACC_W    (ACC_W),
      .COEFF    (fir103_pkg::COEFFS[k])
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (in_xfer),
      .sample_i (sample),
      .sum_i    (chain[k+1]),
      .sum_o    (chain[k])
    );
  end

  // floor scaling and output packing
  assign shifted       = chain[0] >>> fir103_pkg::OUTPUT_SHIFT;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    {(fir103_pkg::OUT_TDATA_W - fir103_pkg::FILTERED_W){1'b0}},
    shifted[fir103_pkg::FILTERED_W-1:0]
  };

endmodule

`default_nettype wire
